>>> src/rqmh_pkg.sv
// shared types and constants of the range qualifier
`default_nettype none
package rqmh_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHORT_TO_LONG = 3'd0,
		REG_LONG_TO_SHORT = 3'd1,
		REG_OUTLIER_LIMIT = 3'd2,
		REG_SHORT_STUCK   = 3'd3,
		REG_LONG_STUCK    = 3'd4,
		REG_SHORT_BASE    = 3'd5,
		REG_LONG_BASE     = 3'd6,
		REG_NOISE_REF     = 3'd7
	} cfg_reg_t;

	// register values after reset
	localparam logic [15:0] RST_SHORT_TO_LONG = 16'd1150;
	localparam logic [15:0] RST_LONG_TO_SHORT = 16'd950;
	localparam logic [15:0] RST_OUTLIER_LIMIT = 16'd5000;
	localparam logic [7:0]  RST_SHORT_STUCK   = 8'd40;
	localparam logic [7:0]  RST_LONG_STUCK    = 8'd6;
	localparam logic [15:0] RST_SHORT_BASE    = 16'd2500;
	localparam logic [15:0] RST_LONG_BASE     = 16'd5000;
	localparam logic [15:0] RST_NOISE_REF     = 16'd2500;

	// sensor status codes
	localparam logic [7:0] STATUS_VALID   = 8'd0;
	localparam logic [7:0] STATUS_NO_WRAP = 8'd6;

	localparam logic [7:0] BAD_COUNT_MAX = 8'd255;

	// fixed point noise model: log2(80)/1500 in Q24, ln2 and one in Q30
	localparam logic [16:0] LOG2_COEF_Q24 = 17'd70710;
	localparam logic [63:0] LN2_Q30       = 64'd744261118;
	localparam logic [63:0] ONE_Q30       = 64'd1073741824;
	localparam int          TAYLOR_TERMS  = 48;

	// shared multiplier operand widths
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 24;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	typedef struct packed {
		logic        data_ready;
		logic        read_ok;
		logic [7:0]  range_status;
		logic [15:0] range_mm;
	} meas_beat_t;

	typedef struct packed {
		logic        sample_valid;
		logic [15:0] distance_mm;
		logic [23:0] std_um;
		logic        mode_now;
		logic        switch_mode;
		logic        restart;
	} result_beat_t;

	// between the top level and the noise sequencer
	typedef struct packed {
		logic        start;
		logic [15:0] base_um;
		logic [15:0] range_mm;
		logic [15:0] ref_mm;
	} noise_req_t;

	typedef struct packed {
		logic        done;
		logic [23:0] std_um;
	} noise_rsp_t;

endpackage
`default_nettype wire

>>> src/range_qualifier_mode_hysteresis.sv
// top level of the range sample qualifier with mode hysteresis and noise model
// usage:
//  - one measurement beat per sensor period on meas (valid/stall), one result
//    beat per measurement on result (valid/stall)
//  - the sample is judged at the accepting edge: mode, bad count and skip flag
//    update there, and the deviation is worked out afterwards
//  - the noise sequencer runs every item through four passes of one 32x24
//    multiplier and two table reads; a new measurement is taken only once
//    the previous result has entered the output register
//  - meas_stall is high while an item is in flight or its result waits to
//    enter the output register; the output register itself may still hold
//    an earlier result, so a slow receiver costs at most one item of slack
//  - a stalled result stays in the output register unchanged
//  - reset gives short mode, zero bad count, no skip and the register
//    defaults; config writes go through cfg_wen, cfg_index, cfg_data, and the
//    user must write only while the block is idle, which it does not enforce
//  - registers: 0 short_to_long_mm, 1 long_to_short_mm, 2 outlier_limit_mm,
//    3 short_stuck_limit, 4 long_stuck_limit, 5 short_std_base_um,
//    6 long_std_base_um, 7 noise_ref_mm
`default_nettype none
module range_qualifier_mode_hysteresis
	import rqmh_pkg::*;
#(
	parameter int EXP_TABLE_DEPTH = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  meas_valid,
	output logic                       meas_stall,
	input  wire meas_beat_t            meas,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_beat_t               result,
	input  wire logic                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [15:0] short_to_long_q;
	logic [15:0] long_to_short_q;
	logic [15:0] outlier_limit_q;
	logic [7:0]  short_stuck_q;
	logic [7:0]  long_stuck_q;
	logic [15:0] short_base_q;
	logic [15:0] long_base_q;
	logic [15:0] noise_ref_q;

	// qualifier state
	logic        long_mode_q;
	logic [7:0]  bad_count_q;
	logic        skip_next_q;
	logic        busy_q;

	// fields held for the result beat while the deviation is computed
	logic        valid_hold_q;
	logic [15:0] dist_hold_q;
	logic        mode_hold_q;
	logic        switch_hold_q;
	logic        restart_hold_q;

	logic         result_valid_q;
	result_beat_t result_q;

	logic        accept;
	logic        status_ok;
	logic        good;
	logic        to_long;
	logic        to_short;
	logic        switch_d;
	logic [7:0]  bad_inc;
	logic [7:0]  stuck_limit;
	logic        restart_d;
	logic        load;

	noise_req_t  noise_req;
	noise_rsp_t  noise_rsp;

	assign accept = meas_valid && !meas_stall;
	assign meas_stall = busy_q;

	// sample judgement against the state before this beat
	assign status_ok = (meas.range_status == STATUS_VALID)
		|| (long_mode_q && (meas.range_status == STATUS_NO_WRAP));
	assign good = meas.data_ready && meas.read_ok && status_ok
		&& (meas.range_mm < outlier_limit_q);

	assign to_long  = !long_mode_q && (meas.range_mm > short_to_long_q);
	assign to_short = long_mode_q && (meas.range_mm < long_to_short_q);
	assign switch_d = !skip_next_q && good && (to_long || to_short);

	// bad count saturates, then the per-mode limit decides on a restart
	assign bad_inc     = (bad_count_q == BAD_COUNT_MAX) ? BAD_COUNT_MAX : bad_count_q + 8'd1;
	assign stuck_limit = long_mode_q ? long_stuck_q : short_stuck_q;
	assign restart_d   = !skip_next_q && !good && (bad_inc > stuck_limit);

	// deviation uses the base of the mode the sample was taken in
	assign noise_req.start    = accept;
	assign noise_req.base_um  = long_mode_q ? long_base_q : short_base_q;
	assign noise_req.range_mm = meas.range_mm;
	assign noise_req.ref_mm   = noise_ref_q;

	rqmh_noise_seq #(
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
	) u_noise (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (noise_req),
		.ack    (load),
		.rsp    (noise_rsp)
	);

	// finished item enters the output register once the slot is free
	assign load = noise_rsp.done && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_to_long_q <= RST_SHORT_TO_LONG;
			long_to_short_q <= RST_LONG_TO_SHORT;
			outlier_limit_q <= RST_OUTLIER_LIMIT;
			short_stuck_q   <= RST_SHORT_STUCK;
			long_stuck_q    <= RST_LONG_STUCK;
			short_base_q    <= RST_SHORT_BASE;
			long_base_q     <= RST_LONG_BASE;
			noise_ref_q     <= RST_NOISE_REF;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_SHORT_TO_LONG: short_to_long_q <= cfg_data;
				REG_LONG_TO_SHORT: long_to_short_q <= cfg_data;
				REG_OUTLIER_LIMIT: outlier_limit_q <= cfg_data;
				REG_SHORT_STUCK:   short_stuck_q   <= cfg_data[7:0];
				REG_LONG_STUCK:    long_stuck_q    <= cfg_data[7:0];
				REG_SHORT_BASE:    short_base_q    <= cfg_data;
				REG_LONG_BASE:     long_base_q     <= cfg_data;
				REG_NOISE_REF:     noise_ref_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_mode_q <= 1'b0;
			bad_count_q <= '0;
			skip_next_q <= 1'b0;
		end else if (accept) begin
			if (skip_next_q) begin
				// sample right after a mode switch is dropped
				skip_next_q <= 1'b0;
				bad_count_q <= '0;
			end else if (good) begin
				bad_count_q <= '0;
				skip_next_q <= switch_d;
				if (switch_d) begin
					long_mode_q <= !long_mode_q;
				end
			end else begin
				bad_count_q <= restart_d ? 8'd0 : bad_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (load) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			valid_hold_q   <= !skip_next_q && good;
			dist_hold_q    <= (!skip_next_q && good) ? meas.range_mm : 16'd0;
			mode_hold_q    <= switch_d ? !long_mode_q : long_mode_q;
			switch_hold_q  <= switch_d;
			restart_hold_q <= restart_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.sample_valid <= valid_hold_q;
			result_q.distance_mm  <= dist_hold_q;
			result_q.std_um       <= valid_hold_q ? noise_rsp.std_um : 24'd0;
			result_q.mode_now     <= mode_hold_q;
			result_q.switch_mode  <= switch_hold_q;
			result_q.restart      <= restart_hold_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

>>> src/rqmh_mul.sv
// shared unsigned multiplier with registered product
`default_nettype none
module rqmh_mul
	import rqmh_pkg::*;
(
	input  wire logic               clk,
	input  wire logic [MUL_A_W-1:0] a,
	input  wire logic [MUL_B_W-1:0] b,
	output logic      [MUL_P_W-1:0] prod
);

	logic [MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= {{MUL_B_W{1'b0}}, a} * {{MUL_A_W{1'b0}}, b};
	end

	assign prod = prod_q;

endmodule
`default_nettype wire

>>> src/rqmh_exp_rom.sv
// constant table of 2^(i/depth) in q30 with registered read
`default_nettype none
module rqmh_exp_rom
	import rqmh_pkg::*;
#(
	parameter int EXP_TABLE_DEPTH = 64
) (
	input  wire logic                                 clk,
	input  wire logic [$clog2(EXP_TABLE_DEPTH+1)-1:0] addr,
	output logic      [31:0]                          data
);

	localparam int AW = $clog2(EXP_TABLE_DEPTH + 1);

	// truncated integer taylor series of exp(i*ln2/depth)
	function automatic logic [31:0] tab_entry(input int unsigned i);
		logic [63:0] arg;
		logic [63:0] t;
		logic [63:0] s;
		arg = (LN2_Q30 * 64'(i)) / EXP_TABLE_DEPTH;
		t = ONE_Q30;
		s = ONE_Q30;
		for (int n = 1; n < TAYLOR_TERMS; n++) begin
			if (t != 64'd0) begin
				t = ((t * arg) >> 30) / 64'(n);
				s = s + t;
			end
		end
		return s[31:0];
	endfunction

	logic [31:0] tab [EXP_TABLE_DEPTH+1];
	logic [31:0] data_q;

	for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_tab
		localparam logic [31:0] ENTRY = tab_entry(g);
		assign tab[g] = ENTRY;
	end

	always_ff @(posedge clk) begin
		if (addr <= AW'(EXP_TABLE_DEPTH)) begin
			data_q <= tab[addr];
		end else begin
			data_q <= '0;
		end
	end

	assign data = data_q;

endmodule
`default_nettype wire

>>> src/rqmh_noise_seq.sv
// sequencer for base*(1+2^y) over the shared multiplier and the table
`default_nettype none
module rqmh_noise_seq
	import rqmh_pkg::*;
#(
	parameter int EXP_TABLE_DEPTH = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire noise_req_t req,
	input  wire logic       ack,
	output noise_rsp_t      rsp
);

	localparam int AW   = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int IDXW = $clog2(EXP_TABLE_DEPTH);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_Y    = 8'b0000_0010,
		S_POS  = 8'b0000_0100,
		S_LO   = 8'b0000_1000,
		S_HI   = 8'b0001_0000,
		S_MIX  = 8'b0010_0000,
		S_TERM = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} seq_state_t;

	seq_state_t state_q, state_d;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod;
	logic [AW-1:0]      rom_addr;
	logic [31:0]        rom_data;

	logic [16:0]        diff;
	logic [15:0]        diff_abs;
	logic [34:0]        y_val;
	logic [IDXW-1:0]    idx;
	logic [31:0]        mant;
	logic [5:0]         shamt;
	logic [47:0]        term;
	logic [48:0]        total;
	logic [23:0]        std_d;

	logic [15:0]        base_q;
	logic               neg_q;
	logic signed [10:0] ip_q;
	logic [IDXW-1:0]    idx_q;
	logic [23:0]        w_q;
	logic [31:0]        lo_q;
	logic [23:0]        std_q;

	rqmh_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	rqmh_exp_rom #(
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	assign diff     = {1'b0, req.range_mm} - {1'b0, req.ref_mm};
	assign diff_abs = diff[16] ? 16'(-diff) : diff[15:0];

	// signed exponent in log2 units, q24
	assign y_val = neg_q ? 35'(-{2'b00, prod[32:0]}) : {2'b00, prod[32:0]};

	assign idx  = prod[24 +: IDXW];
	assign mant = 32'(lo_q + prod[55:24]);

	assign shamt = 6'(11'd30 - ip_q);
	assign term  = prod[47:0] >> shamt;

	always_comb begin
		total = '0;
		if (base_q == 16'd0) begin
			std_d = '0;
		end else if (ip_q >= 11'sd24) begin
			std_d = '1;
		end else begin
			if (ip_q < -11'sd33) begin
				total = 49'(base_q);
			end else begin
				total = {1'b0, term} + 49'(base_q);
			end
			std_d = (|total[48:24]) ? '1 : total[23:0];
		end
	end

	// operand selection for the shared multiplier
	always_comb begin
		case (state_q)
			S_IDLE: begin
				mul_a = MUL_A_W'(diff_abs);
				mul_b = MUL_B_W'(LOG2_COEF_Q24);
			end
			S_Y: begin
				mul_a = MUL_A_W'(y_val[23:0]);
				mul_b = MUL_B_W'(EXP_TABLE_DEPTH);
			end
			S_HI: begin
				mul_a = rom_data - lo_q;
				mul_b = w_q;
			end
			S_MIX: begin
				mul_a = mant;
				mul_b = MUL_B_W'(base_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign rom_addr = (state_q == S_POS) ? AW'(idx) : AW'(idx_q) + AW'(1);

	always_comb begin
		case (state_q)
			S_IDLE:  state_d = req.start ? S_Y : S_IDLE;
			S_Y:     state_d = S_POS;
			S_POS:   state_d = S_LO;
			S_LO:    state_d = S_HI;
			S_HI:    state_d = S_MIX;
			S_MIX:   state_d = S_TERM;
			S_TERM:  state_d = S_DONE;
			S_DONE:  state_d = ack ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.start) begin
					base_q <= req.base_um;
					neg_q  <= diff[16];
				end
			end
			S_Y: begin
				ip_q <= y_val[34:24];
			end
			S_POS: begin
				idx_q <= idx;
				w_q   <= prod[23:0];
			end
			S_LO: begin
				lo_q <= rom_data;
			end
			S_TERM: begin
				std_q <= std_d;
			end
			default: begin
			end
		endcase
	end

	assign rsp.done   = (state_q == S_DONE);
	assign rsp.std_um = std_q;

endmodule
`default_nettype wire

>>> tb/rqmh_result_check.sv
// result checker of the range qualifier: predicts every result beat and compares it
module rqmh_result_check
	import rqmh_pkg::*;
#(
	parameter int EXP_TABLE_DEPTH = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  meas_valid,
	input  wire logic                  meas_stall,
	input  wire meas_beat_t            meas,
	input  wire logic                  result_valid,
	input  wire logic                  result_stall,
	input  wire result_beat_t          result,
	input  wire logic                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fails,
	output int                         pending
);

	localparam longint Y_OFFSET_INT = 512;
	localparam logic [63:0] STD_SAT = 64'd16777215;

	// 2^(i/depth) in Q30
	logic [63:0] pow2_frac_q30 [0:EXP_TABLE_DEPTH];

	// register copies
	logic [15:0] short_to_long, long_to_short, outlier_mm;
	logic [7:0]  short_stuck, long_stuck;
	logic [15:0] short_base, long_base, noise_ref;

	// qualifier state
	logic        in_long_mode;
	logic [7:0]  bad_run;
	logic        skip_pending;

	result_beat_t expected_results [$];
	result_beat_t want;
	int           meas_seen;
	int           results_seen;

	assign pending = meas_seen - results_seen;

	initial begin
		logic [63:0] a, t, sum;
		fails = 0;
		for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
			a = (LN2_Q30 * i) / EXP_TABLE_DEPTH;
			t = ONE_Q30;
			sum = ONE_Q30;
			for (int n = 1; n < TAYLOR_TERMS && t != 0; n++) begin
				t = ((t * a) >> 30) / n;
				sum += t;
			end
			pow2_frac_q30[i] = sum;
		end
	end

	// base * (1 + 2^((d - ref) * log2(80) / 1500)), saturated to 24 bits
	function automatic logic [23:0] noise_dev_um(logic [15:0] d, logic [15:0] base);
		longint      diff, y, ip;
		logic [63:0] u, f, pos, idx, w, lo, hi, m, s, term;
		diff = longint'(d) - longint'(noise_ref);
		y    = diff * longint'(LOG2_COEF_Q24);
		u    = y + (Y_OFFSET_INT << 24);
		ip   = longint'(u >> 24) - Y_OFFSET_INT;
		f    = u & 64'hFF_FFFF;
		pos  = f * EXP_TABLE_DEPTH;
		idx  = (pos >> 24) & 64'hFFFF;
		w    = pos & 64'hFF_FFFF;
		if (base == 0)
			return '0;
		if (idx >= EXP_TABLE_DEPTH)
			idx = 64'(EXP_TABLE_DEPTH - 1);
		lo = pow2_frac_q30[idx];
		hi = pow2_frac_q30[idx + 1];
		m  = lo + (((hi - lo) * w) >> 24);
		if (ip >= 24)
			return STD_SAT[23:0];
		s    = 64'(30 - ip);
		term = (s >= 64) ? 64'd0 : ((64'(base) * m) >> s);
		term += base;
		if (term > STD_SAT)
			term = STD_SAT;
		return term[23:0];
	endfunction

	// judges one sample and advances the qualifier state
	function automatic result_beat_t qualify_sample(meas_beat_t m);
		result_beat_t r;
		logic         good;
		r = '0;
		if (skip_pending) begin
			skip_pending = 1'b0;
			bad_run = '0;
		end else begin
			good = m.data_ready && m.read_ok && (m.range_status == STATUS_VALID ||
				(in_long_mode && m.range_status == STATUS_NO_WRAP));
			if (good && m.range_mm < outlier_mm) begin
				bad_run = '0;
				r.sample_valid = 1'b1;
				r.distance_mm = m.range_mm;
				r.std_um = noise_dev_um(m.range_mm, in_long_mode ? long_base : short_base);
				if (!in_long_mode && m.range_mm > short_to_long) begin
					in_long_mode = 1'b1;
					r.switch_mode = 1'b1;
				end else if (in_long_mode && m.range_mm < long_to_short) begin
					in_long_mode = 1'b0;
					r.switch_mode = 1'b1;
				end
				skip_pending = r.switch_mode;
			end else begin
				if (bad_run != BAD_COUNT_MAX)
					bad_run++;
				if (bad_run > (in_long_mode ? long_stuck : short_stuck)) begin
					r.restart = 1'b1;
					bad_run = '0;
				end
			end
		end
		r.mode_now = in_long_mode;
		return r;
	endfunction

	task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v != act_v) begin
			fails++;
			$display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_to_long <= RST_SHORT_TO_LONG;
			long_to_short <= RST_LONG_TO_SHORT;
			outlier_mm    <= RST_OUTLIER_LIMIT;
			short_stuck   <= RST_SHORT_STUCK;
			long_stuck    <= RST_LONG_STUCK;
			short_base    <= RST_SHORT_BASE;
			long_base     <= RST_LONG_BASE;
			noise_ref     <= RST_NOISE_REF;
			in_long_mode  = 1'b0;
			bad_run       = '0;
			skip_pending  = 1'b0;
			expected_results.delete();
			meas_seen     <= 0;
			results_seen  <= 0;
		end else begin
			// result first: a beat leaving now belongs to an older sample
			if (result_valid && !result_stall) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					fails++;
					$display("%0t mismatch result beat: expected none actual %p", $time, result);
				end else begin
					want = expected_results.pop_front();
					check_field("sample_valid", want.sample_valid, result.sample_valid);
					check_field("distance_mm", want.distance_mm, result.distance_mm);
					check_field("std_um", want.std_um, result.std_um);
					check_field("mode_now", want.mode_now, result.mode_now);
					check_field("switch_mode", want.switch_mode, result.switch_mode);
					check_field("restart", want.restart, result.restart);
				end
			end
			if (meas_valid && !meas_stall) begin
				expected_results.push_back(qualify_sample(meas));
				meas_seen <= meas_seen + 1;
			end
			if (cfg_wen) begin
				case (cfg_index)
					REG_SHORT_TO_LONG: short_to_long <= cfg_data;
					REG_LONG_TO_SHORT: long_to_short <= cfg_data;
					REG_OUTLIER_LIMIT: outlier_mm    <= cfg_data;
					REG_SHORT_STUCK:   short_stuck   <= cfg_data[7:0];
					REG_LONG_STUCK:    long_stuck    <= cfg_data[7:0];
					REG_SHORT_BASE:    short_base    <= cfg_data;
					REG_LONG_BASE:     long_base     <= cfg_data;
					REG_NOISE_REF:     noise_ref     <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

>>> tb/tb_range_qualifier_mode_hysteresis.sv
// testbench top of the range qualifier: stimulus, idling phases and verdict
module tb_range_qualifier_mode_hysteresis;
	import rqmh_pkg::*;

	localparam int EXP_TABLE_DEPTH = 64;
	localparam int PHASE_BEATS     = 200;
	localparam int PHASES          = 8;
	// the limit leaves ample margin over the slowest correct run
	localparam int CYCLE_LIMIT     = 600000;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  meas_valid   = 1'b0;
	logic                  meas_stall;
	meas_beat_t            meas         = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_beat_t          result;
	logic                  cfg_wen      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	int fails;
	int pending;
	int cycles = 0;

	// idling knobs, percent per cycle
	int src_idle_pct  = 0;
	int sink_stall_pct = 0;
	// long receiver hold-off, requested here and counted down in the receiver process
	int hold_len  = 0;
	int hold_left = 0;
	// remaining beats of a deliberate run of bad samples
	int bad_burst = 0;

	// register values in force, indexed by register name
	logic [15:0] cfg_vals [0:7];

	range_qualifier_mode_hysteresis #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.meas_valid  (meas_valid),
		.meas_stall  (meas_stall),
		.meas        (meas),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	rqmh_result_check #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.meas_valid  (meas_valid),
		.meas_stall  (meas_stall),
		.meas        (meas),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fails       (fails),
		.pending     (pending)
	);

	always #5 clk = ~clk;

	// watchdog: a hung handshake or a lost result ends here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: random stall, plus the long hold-off when one is requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				hold_left = hold_len;
				hold_len = 0;
			end
			result_stall <= (hold_left > 0) || ($urandom_range(0, 99) < sink_stall_pct);
			if (hold_left > 0)
				hold_left--;
		end
	end

	function automatic meas_beat_t meas_of(logic ready, logic ok, logic [7:0] status,
		logic [15:0] range_mm);
		meas_beat_t b;
		b.data_ready   = ready;
		b.read_ok      = ok;
		b.range_status = status;
		b.range_mm     = range_mm;
		return b;
	endfunction

	// random sample: mostly well-formed beats around the thresholds, some noise,
	// and now and then a run of bad samples to drive the stuck counter
	function automatic meas_beat_t next_measurement();
		meas_beat_t b;
		int         r;
		int         pick;
		b.data_ready   = 1'b1;
		b.read_ok      = 1'b1;
		b.range_status = ($urandom_range(0, 4) == 0) ? STATUS_NO_WRAP : STATUS_VALID;
		b.range_mm     = '0;
		pick = $urandom_range(0, 99);
		if (bad_burst == 0 && $urandom_range(0, 39) == 0)
			bad_burst = $urandom_range(1, 14);
		if (bad_burst > 0) begin
			bad_burst--;
			b.range_mm = 16'($urandom_range(0, int'(cfg_vals[REG_OUTLIER_LIMIT])));
			case ($urandom_range(0, 3))
				0: b.data_ready = 1'b0;
				1: b.read_ok = 1'b0;
				2: begin
					b.range_status = 8'($urandom_range(1, 255));
					if (b.range_status == STATUS_NO_WRAP)
						b.range_status = STATUS_NO_WRAP + 8'd1;
				end
				default: begin
					if (cfg_vals[REG_OUTLIER_LIMIT] == 16'hFFFF)
						b.data_ready = 1'b0;
					else
						b.range_mm = 16'($urandom_range(int'(cfg_vals[REG_OUTLIER_LIMIT]),
							65535));
				end
			endcase
			return b;
		end
		if (pick < 15) begin
			// noise over the whole field space
			b.data_ready   = 1'($urandom_range(0, 1));
			b.read_ok      = 1'($urandom_range(0, 1));
			b.range_status = 8'($urandom_range(0, 255));
			b.range_mm     = 16'($urandom_range(0, 65535));
			return b;
		end
		if (pick < 45)
			r = int'(cfg_vals[REG_SHORT_TO_LONG]) + int'($urandom_range(0, 400)) - 200;
		else if (pick < 70)
			r = int'(cfg_vals[REG_LONG_TO_SHORT]) + int'($urandom_range(0, 400)) - 200;
		else if (pick < 85)
			r = int'(cfg_vals[REG_NOISE_REF]) + int'($urandom_range(0, 3000)) - 1500;
		else if (pick < 95)
			r = $urandom_range(0, int'(cfg_vals[REG_OUTLIER_LIMIT]));
		else
			r = int'(cfg_vals[REG_OUTLIER_LIMIT]) + int'($urandom_range(0, 6)) - 3;
		if (r < 0)
			r = 0;
		if (r > 65535)
			r = 65535;
		b.range_mm = r[15:0];
		return b;
	endfunction

	// offer one measurement beat and hold it until it is taken
	task automatic offer_measurement(meas_beat_t b);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			meas_valid <= 1'b0;
			@(posedge clk);
		end
		meas_valid <= 1'b1;
		meas <= b;
		@(posedge clk);
		while (meas_stall)
			@(posedge clk);
	endtask

	// sender quiet until every predicted result has been taken
	task automatic wait_drained();
		meas_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// write all eight registers back to back, only while the block is idle
	task automatic program_regs();
		cfg_reg_t r;
		r = r.first();
		repeat (r.num()) begin
			cfg_wen   <= 1'b1;
			cfg_index <= r;
			cfg_data  <= cfg_vals[r];
			@(posedge clk);
			r = r.next();
		end
		cfg_wen <= 1'b0;
	endtask

	task automatic load_defaults();
		cfg_vals[REG_SHORT_TO_LONG] = RST_SHORT_TO_LONG;
		cfg_vals[REG_LONG_TO_SHORT] = RST_LONG_TO_SHORT;
		cfg_vals[REG_OUTLIER_LIMIT] = RST_OUTLIER_LIMIT;
		cfg_vals[REG_SHORT_STUCK]   = 16'(RST_SHORT_STUCK);
		cfg_vals[REG_LONG_STUCK]    = 16'(RST_LONG_STUCK);
		cfg_vals[REG_SHORT_BASE]    = RST_SHORT_BASE;
		cfg_vals[REG_LONG_BASE]     = RST_LONG_BASE;
		cfg_vals[REG_NOISE_REF]     = RST_NOISE_REF;
	endtask

	// random but plausible setting; now and then the hysteresis is inverted
	task automatic load_random_cfg();
		int stl;
		int lts;
		stl = $urandom_range(300, 4000);
		if ($urandom_range(0, 9) == 0)
			lts = stl + int'($urandom_range(0, 500));
		else
			lts = stl - int'($urandom_range(0, 600));
		if (lts < 0)
			lts = 0;
		cfg_vals[REG_SHORT_TO_LONG] = stl[15:0];
		cfg_vals[REG_LONG_TO_SHORT] = lts[15:0];
		cfg_vals[REG_OUTLIER_LIMIT] = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535)) :
			16'($urandom_range(stl, 9000));
		cfg_vals[REG_SHORT_STUCK]   = 16'($urandom_range(0, 12));
		cfg_vals[REG_LONG_STUCK]    = 16'($urandom_range(0, 12));
		cfg_vals[REG_SHORT_BASE]    = 16'($urandom_range(0, 65535));
		cfg_vals[REG_LONG_BASE]     = 16'($urandom_range(0, 65535));
		cfg_vals[REG_NOISE_REF]     = 16'($urandom_range(0, 8000));
	endtask

	initial begin
		load_defaults();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats on the reset setting, no idling
		offer_measurement(meas_of(1'b1, 1'b1, STATUS_VALID, 16'd0));       // shortest range
		offer_measurement(meas_of(1'b0, 1'b1, STATUS_VALID, 16'd500));     // no data ready
		offer_measurement(meas_of(1'b1, 1'b0, STATUS_VALID, 16'd500));     // bus error
		offer_measurement(meas_of(1'b1, 1'b1, STATUS_NO_WRAP, 16'd500));   // no-wrap refused in short
		offer_measurement(meas_of(1'b1, 1'b1, 8'hFF, 16'd500));            // other status code
		offer_measurement(meas_of(1'b1, 1'b1, STATUS_VALID, 16'd1150));    // on the threshold, stays
		offer_measurement(meas_of(1'b1, 1'b1, STATUS_VALID, 16'd1151));    // into long mode
		offer_measurement(meas_of(1'b1, 1'b1, STATUS_VALID, 16'd3000));    // skipped after switch
		offer_measurement(meas_of(1'b1, 1'b1, STATUS_NO_WRAP, 16'd4999));  // no-wrap good in long
		offer_measurement(meas_of(1'b1, 1'b1, STATUS_VALID, 16'd5000));    // outlier
		offer_measurement(meas_of(1'b1, 1'b1, STATUS_VALID, 16'hFFFF));    // largest range
		repeat (5)                                                         // long stuck limit passed
			offer_measurement(meas_of(1'b0, 1'b0, STATUS_VALID, 16'd2000));
		offer_measurement(meas_of(1'b1, 1'b1, STATUS_VALID, 16'd950));     // on the threshold, stays
		offer_measurement(meas_of(1'b1, 1'b1, STATUS_VALID, 16'd949));     // back to short mode
		offer_measurement(meas_of(1'b1, 1'b1, STATUS_VALID, 16'd949));     // skipped after switch
		offer_measurement(meas_of(1'b1, 1'b1, STATUS_VALID, 16'd2500));    // at the noise reference
		wait_drained();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: ;                      // reset setting, never written
				1: begin
					// deviation saturates far above a zero reference
					load_defaults();
					cfg_vals[REG_OUTLIER_LIMIT] = 16'hFFFF;
					cfg_vals[REG_SHORT_STUCK]   = 16'd3;
					cfg_vals[REG_LONG_STUCK]    = 16'd2;
					cfg_vals[REG_NOISE_REF]     = 16'd0;
				end
				3: begin
					// good beats switch unless skipped or zero in short mode, restart on each bad one not skipped
					cfg_vals[REG_SHORT_TO_LONG] = 16'd0;
					cfg_vals[REG_LONG_TO_SHORT] = 16'hFFFF;
					cfg_vals[REG_OUTLIER_LIMIT] = 16'hFFFF;
					cfg_vals[REG_SHORT_STUCK]   = 16'd0;
					cfg_vals[REG_LONG_STUCK]    = 16'd0;
					cfg_vals[REG_SHORT_BASE]    = 16'hFFFF;
					cfg_vals[REG_LONG_BASE]     = 16'hFFFF;
					cfg_vals[REG_NOISE_REF]     = 16'hFFFF;
				end
				5: begin
					// nothing passes, bad count climbs with no restart, zero bases
					cfg_vals[REG_SHORT_TO_LONG] = 16'd0;
					cfg_vals[REG_LONG_TO_SHORT] = 16'd0;
					cfg_vals[REG_OUTLIER_LIMIT] = 16'd0;
					cfg_vals[REG_SHORT_STUCK]   = 16'd255;
					cfg_vals[REG_LONG_STUCK]    = 16'd255;
					cfg_vals[REG_SHORT_BASE]    = 16'd0;
					cfg_vals[REG_LONG_BASE]     = 16'd0;
					cfg_vals[REG_NOISE_REF]     = 16'd0;
				end
				7: load_defaults();
				default: load_random_cfg();
			endcase
			if (phase != 0)
				program_regs();

			// idling pattern cycles through none, sender, receiver, both
			case (phase % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 66; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 66; end
				default: begin src_idle_pct = 28; sink_stall_pct = 28; end
			endcase
			// long hold-off while the sender keeps offering, so the input backs up
			if (phase == 2)
				hold_len = 400;

			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (phase == 4 && n == PHASE_BEATS / 2)
					wait_drained();
				offer_measurement(next_measurement());
			end
			wait_drained();
		end

		// tail: any stray result beat would still show up here
		repeat (24) @(posedge clk);
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
